/* design/ptdt_pkg.sv */
// Package for the periodic task dispatch table.
// Holds command and error codes, sequencer states and the result type.
`default_nettype none
package ptdt_pkg;
  typedef enum logic [2:0] {
    CMD_REGISTER   = 3'd0,
    CMD_UNREGISTER = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_QUERY      = 3'd3,
    CMD_TICK       = 3'd4
  } cmd_e;
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NULL     = 3'd1,
    ERR_DUP      = 3'd2,
    ERR_FULL     = 3'd3,
    ERR_NOTFOUND = 3'd4
  } err_e;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_ACT,
    ST_TICK,
    ST_OUT
  } state_e;
  localparam logic [31:0] DUE_HALF = 32'h8000_0000;
  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [2:0]  err;
    logic [15:0] handler;
    logic [31:0] context_word;
    logic        last;
  } result_t;
endpackage
`default_nettype wire

/* design/periodic_task_dispatch_table_top.sv */
// Top level of the periodic task dispatch table: linked task list walked
// by one sequencer. Depends on ptdt_pkg.
//
// Channel | Dir | Payload
// s_axis  | in  | tdata: command, handler_id, context_word, period_ms,
//         |     |        start_delay_ms, current_time_ms
// m_axis  | out | tdata: success, error_code, fired_handler, fired_context;
//         |     | tuser: result_kind; tlast: last_of_run
// A search or a tick walks the list from the head, and each result waits
// until the output side takes it.
// The block is not ready while a request is in work or a result waits.
// Reset empties the list at once; entry data is not cleared.
`default_nettype none
module periodic_task_dispatch_table_top #(
  parameter int TASK_SLOTS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command[2:0], handler_id[18:3], context_word[50:19], period_ms[82:51],
  // start_delay_ms[114:83], current_time_ms[146:115], zero fill
  input  wire logic [151:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // success[0], error_code[3:1], fired_handler[19:4], fired_context[51:20], zero fill
  output logic [55:0]       m_axis_tdata,
  // result_kind[0]
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);
  import ptdt_pkg::*;
  localparam int LW = $clog2(TASK_SLOTS + 1);
  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [LW-1:0] NIL = LW'(TASK_SLOTS);
  localparam logic [LW:0] STEPS = (LW+1)'(TASK_SLOTS);

  logic [15:0] hnd_q [TASK_SLOTS];
  logic [31:0] ctx_q [TASK_SLOTS];
  logic [31:0] per_q [TASK_SLOTS];
  logic [31:0] due_q [TASK_SLOTS];
  logic [LW-1:0] lnk_q [TASK_SLOTS];
  logic [LW-1:0] head_q, tail_q, free_q, cur_q, prev_q, found_q;
  logic [LW:0] steps_q;
  logic [4:0] nout_q;
  state_e st_q, st_d;
  logic [2:0] cmd_q;
  logic [15:0] id_q;
  logic [31:0] ictx_q, iper_q, idly_q, now_q;
  result_t res_q;
  logic res_v_q;
  logic hold_q;

  logic acc, out_fire, cur_ok, walk_end, req_null, due_hit;
  logic [IW-1:0] ci;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && !res_v_q;
  assign ci = cur_q[IW-1:0];
  assign cur_ok = (cur_q < NIL);
  assign walk_end = !cur_ok || (steps_q >= STEPS);
  assign req_null = (s_axis_tdata[18:3] == 16'd0) &&
                    (s_axis_tdata[2:0] == CMD_REGISTER || s_axis_tdata[2:0] == CMD_UNREGISTER
                     || s_axis_tdata[2:0] == CMD_QUERY);
  assign due_hit = (now_q - due_q[ci]) < DUE_HALF;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (acc) begin
        case (s_axis_tdata[2:0])
          CMD_TICK: st_d = ST_TICK;
          CMD_REGISTER, CMD_UNREGISTER, CMD_QUERY:
            st_d = (s_axis_tdata[18:3] == 16'd0) ? ST_OUT : ST_FIND;
          default: st_d = ST_OUT;
        endcase
      end
      ST_FIND: if (walk_end || hnd_q[ci] == id_q) st_d = ST_ACT;
      ST_ACT:  st_d = ST_OUT;
      ST_TICK: if (walk_end || nout_q == 5'd16) st_d = ST_OUT;
      ST_OUT:  if (!res_v_q) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && acc) begin
      cmd_q  <= s_axis_tdata[2:0];
      id_q   <= s_axis_tdata[18:3];
      ictx_q <= s_axis_tdata[50:19];
      iper_q <= s_axis_tdata[82:51];
      idly_q <= s_axis_tdata[114:83];
      now_q  <= s_axis_tdata[146:115];
    end
  end

  // Entry data has no reset.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_ACT && cmd_q == CMD_REGISTER && free_q < NIL && found_q == NIL) begin
      hnd_q[free_q[IW-1:0]] <= id_q;
      ctx_q[free_q[IW-1:0]] <= ictx_q;
      per_q[free_q[IW-1:0]] <= iper_q - (iper_q >> 6) - (iper_q >> 9);
      due_q[free_q[IW-1:0]] <= now_q + idly_q;
    end else if (st_q == ST_TICK && st_d == ST_TICK && due_hit && !hold_q
                 && !res_v_q) begin
      due_q[ci] <= now_q + per_q[ci];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      res_v_q <= 1'b0;
      hold_q <= 1'b0;
      head_q <= NIL;
      tail_q <= NIL;
      free_q <= '0;
      cur_q <= NIL;
      prev_q <= NIL;
      found_q <= NIL;
      steps_q <= '0;
      nout_q <= '0;
      res_q <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) lnk_q[i] <= LW'(i + 1);
    end else begin
      if (out_fire) res_v_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (acc) begin
          st_q <= st_d;
          cur_q <= head_q;
          prev_q <= NIL;
          found_q <= NIL;
          steps_q <= '0;
          nout_q <= '0;
          hold_q <= 1'b0;
          res_q <= '{kind: 1'b0, ok: (s_axis_tdata[2:0] == CMD_CLEAR),
                     err: req_null ? ERR_NULL : ERR_NONE, handler: '0,
                     context_word: '0, last: 1'b1};
          if (s_axis_tdata[2:0] == CMD_CLEAR) begin
            head_q <= NIL;
            tail_q <= NIL;
            free_q <= '0;
            for (int i = 0; i < TASK_SLOTS; i++) lnk_q[i] <= LW'(i + 1);
          end
        end
        ST_FIND: begin
          st_q <= st_d;
          if (!walk_end) begin
            if (hnd_q[ci] == id_q) found_q <= cur_q;
            else begin
              prev_q <= cur_q;
              cur_q <= lnk_q[ci];
              steps_q <= steps_q + 1'b1;
            end
          end
        end
        ST_ACT: begin
          st_q <= st_d;
          case (cmd_q)
            CMD_REGISTER: begin
              if (found_q != NIL) res_q.err <= ERR_DUP;
              else if (free_q >= NIL) res_q.err <= ERR_FULL;
              else begin
                res_q.ok <= 1'b1;
                free_q <= lnk_q[free_q[IW-1:0]];
                lnk_q[free_q[IW-1:0]] <= NIL;
                if (tail_q < NIL) lnk_q[tail_q[IW-1:0]] <= free_q;
                else head_q <= free_q;
                tail_q <= free_q;
              end
            end
            CMD_UNREGISTER: begin
              if (found_q == NIL) res_q.err <= ERR_NOTFOUND;
              else begin
                res_q.ok <= 1'b1;
                if (prev_q < NIL) lnk_q[prev_q[IW-1:0]] <= lnk_q[found_q[IW-1:0]];
                else head_q <= lnk_q[found_q[IW-1:0]];
                if (tail_q == found_q) tail_q <= prev_q;
                lnk_q[found_q[IW-1:0]] <= free_q;
                free_q <= found_q;
              end
            end
            default: begin
              if (found_q == NIL) res_q.err <= ERR_NOTFOUND;
              else res_q.ok <= 1'b1;
            end
          endcase
        end
        ST_TICK: if (!res_v_q) begin
          if (st_d == ST_OUT) begin
            if (hold_q) begin
              res_q.last <= 1'b1;
              res_v_q <= 1'b1;
              hold_q <= 1'b0;
              st_q <= ST_IDLE;
            end else begin
              res_q <= '{kind: 1'b0, ok: 1'b1, err: ERR_NONE, handler: '0,
                         context_word: '0, last: 1'b1};
              st_q <= ST_OUT;
            end
          end else if (due_hit && hold_q) begin
            res_v_q <= 1'b1;
            hold_q <= 1'b0;
          end else begin
            if (due_hit) begin
              nout_q <= nout_q + 5'd1;
              hold_q <= 1'b1;
              res_q <= '{kind: 1'b1, ok: 1'b1, err: ERR_NONE, handler: hnd_q[ci],
                         context_word: ctx_q[ci], last: 1'b0};
            end
            cur_q <= lnk_q[ci];
            steps_q <= steps_q + 1'b1;
          end
        end
        ST_OUT: begin
          res_v_q <= 1'b1;
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = res_v_q;
  assign m_axis_tdata = {4'd0, res_q.context_word, res_q.handler, res_q.err, res_q.ok};
  assign m_axis_tuser = res_q.kind;
  assign m_axis_tlast = res_q.last;
endmodule
`default_nettype wire

/* design/ptdt_checker.sv */
// Port-level checker for the periodic task dispatch table, bound to the top.
// Depends on ptdt_pkg.
`default_nettype none
module ptdt_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [55:0]  m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         m_axis_tlast
);
  import ptdt_pkg::*;
  a_no_ready_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready with pending result");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after request");
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[0] && m_axis_tdata[3:1] == ERR_NONE))
    else $error("bad firing status");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[51:4] == 48'd0))
    else $error("bad status result");
endmodule
bind periodic_task_dispatch_table_top ptdt_checker u_ptdt_checker (.*);
`default_nettype wire

/* dv/tb_top.sv */
// Testbench for the periodic task dispatch table: drives requests on the input
// stream, predicts every result with a behavioral task list, and checks results.
// Depends on ptdt_pkg and periodic_task_dispatch_table_top.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ptdt_pkg::*;

  localparam int SLOTS = 16;
  localparam int NIL = SLOTS;
  localparam int MAX_FIRE = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] CMD_BAD = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [2:0]  err;
    logic [15:0] handler;
    logic [31:0] ctx;
    logic        last;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  periodic_task_dispatch_table_top #(.TASK_SLOTS(SLOTS)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [15:0] task_id [SLOTS];
  logic [31:0] task_ctx [SLOTS];
  logic [31:0] task_period [SLOTS];
  logic [31:0] task_due [SLOTS];
  int          task_next [SLOTS];
  int          head_slot, tail_slot, free_slot;
  answer_t     expected_answers [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;
  logic [31:0] uptime = 32'd1000;

  function automatic void empty_table();
    for (int i = 0; i < SLOTS; i++) task_next[i] = i + 1;
    head_slot = NIL;
    tail_slot = NIL;
    free_slot = 0;
  endfunction

  function automatic int locate(input logic [15:0] id, output int prior);
    int p, c, n;
    p = NIL;
    c = head_slot;
    n = 0;
    prior = NIL;
    while (c < SLOTS && n < SLOTS) begin
      if (task_id[c] == id) begin
        prior = p;
        return c;
      end
      p = c;
      c = task_next[c];
      n++;
    end
    return NIL;
  endfunction

  function automatic void push_status(input bit ok, input err_e e);
    answer_t a;
    a = '{kind: 1'b0, ok: ok, err: e, handler: '0, ctx: '0, last: 1'b0};
    expected_answers.push_back(a);
  endfunction

  function automatic void predict_dispatch(input logic [2:0] cmd, input logic [15:0] id,
      input logic [31:0] ctx, input logic [31:0] per, input logic [31:0] dly,
      input logic [31:0] now);
    int prior, s, c, n, fired;
    answer_t a;
    case (cmd)
      CMD_REGISTER: begin
        if (id == 0) push_status(1'b0, ERR_NULL);
        else if (locate(id, prior) != NIL) push_status(1'b0, ERR_DUP);
        else if (free_slot >= SLOTS) push_status(1'b0, ERR_FULL);
        else begin
          s = free_slot;
          free_slot = task_next[s];
          task_id[s] = id;
          task_ctx[s] = ctx;
          task_period[s] = per - (per >> 6) - (per >> 9);
          task_due[s] = now + dly;
          task_next[s] = NIL;
          if (tail_slot < SLOTS) task_next[tail_slot] = s;
          else head_slot = s;
          tail_slot = s;
          push_status(1'b1, ERR_NONE);
        end
      end
      CMD_UNREGISTER: begin
        if (id == 0) push_status(1'b0, ERR_NULL);
        else begin
          s = locate(id, prior);
          if (s == NIL) push_status(1'b0, ERR_NOTFOUND);
          else begin
            if (prior < SLOTS) task_next[prior] = task_next[s];
            else head_slot = task_next[s];
            if (tail_slot == s) tail_slot = prior;
            task_next[s] = free_slot;
            free_slot = s;
            push_status(1'b1, ERR_NONE);
          end
        end
      end
      CMD_CLEAR: begin
        empty_table();
        push_status(1'b1, ERR_NONE);
      end
      CMD_QUERY: begin
        if (id == 0) push_status(1'b0, ERR_NULL);
        else if (locate(id, prior) != NIL) push_status(1'b1, ERR_NONE);
        else push_status(1'b0, ERR_NOTFOUND);
      end
      CMD_TICK: begin
        c = head_slot;
        n = 0;
        fired = 0;
        while (c < SLOTS && n < SLOTS && fired < MAX_FIRE) begin
          if (now - task_due[c] < DUE_HALF) begin
            a = '{kind: 1'b1, ok: 1'b1, err: ERR_NONE, handler: task_id[c],
                  ctx: task_ctx[c], last: 1'b0};
            expected_answers.push_back(a);
            task_due[c] = now + task_period[c];
            fired++;
          end
          c = task_next[c];
          n++;
        end
        if (fired == 0) push_status(1'b1, ERR_NONE);
      end
      default: push_status(1'b0, ERR_NONE);
    endcase
    expected_answers[$].last = 1'b1;
  endfunction

  task automatic send_request(input logic [2:0] cmd, input logic [15:0] id,
      input logic [31:0] ctx, input logic [31:0] per, input logic [31:0] dly,
      input logic [31:0] now);
    while (!calm && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= {5'd0, now, dly, per, ctx, id, cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_dispatch(cmd, id, ctx, per, dly, now);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, ok: m_axis_tdata[0], err: m_axis_tdata[3:1],
              handler: m_axis_tdata[19:4], ctx: m_axis_tdata[51:20],
              last: m_axis_tlast};
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        error_count++;
      end else begin
        want = expected_answers.pop_front();
        if (got != want || m_axis_tdata[55:52] != 4'd0) begin
          $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] pick_id();
    return 16'($urandom_range(1, 24));
  endfunction

  task automatic test_status_commands();
    send_request(CMD_REGISTER, 16'd0, 32'hFFFF_FFFF, '1, '1, '1);
    send_request(CMD_UNREGISTER, 16'd0, '0, '0, '0, '0);
    send_request(CMD_QUERY, 16'd0, '0, '0, '0, '0);
    send_request(CMD_QUERY, 16'hFFFF, '0, '0, '0, '0);
    send_request(CMD_UNREGISTER, 16'hFFFF, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, '0, '0);
    send_request(CMD_BAD, 16'hFFFF, '1, '1, '1, '1);
    send_request(CMD_BAD_HI, '0, '0, '0, '0, '0);
  endtask

  task automatic test_fill_and_fire();
    send_request(CMD_REGISTER, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFF0);
    send_request(CMD_REGISTER, 16'hFFFF, '0, '0, '0, '0);
    for (int i = 1; i < SLOTS; i++)
      send_request(CMD_REGISTER, 16'(i), $urandom, 32'($urandom_range(0, 700)),
                   32'(i * 3), 32'hFFFF_FFF0);
    send_request(CMD_REGISTER, 16'd99, '0, '0, '0, '0);
    send_request(CMD_QUERY, 16'd7, '0, '0, '0, '0);
    send_request(CMD_TICK, '0, '0, '0, '0, 32'h0000_0040);
    send_request(CMD_TICK, '0, '0, '0, '0, 32'h8000_0030);
    send_request(CMD_UNREGISTER, 16'd7, '0, '0, '0, '0);
    send_request(CMD_UNREGISTER, 16'hFFFF, '0, '0, '0, '0);
    send_request(CMD_CLEAR, '0, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_schedule(input int count);
    logic [2:0] cmd;
    int r;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 2 && i < count / 2 + 40);
      r = $urandom_range(99);
      if (r < 38) cmd = CMD_REGISTER;
      else if (r < 55) cmd = CMD_UNREGISTER;
      else if (r < 58) cmd = CMD_CLEAR;
      else if (r < 68) cmd = CMD_QUERY;
      else if (r < 97) cmd = CMD_TICK;
      else cmd = 3'($urandom_range(CMD_BAD, CMD_BAD_HI));
      uptime += 32'($urandom_range(0, 300));
      if ($urandom_range(49) == 0) uptime = $urandom;
      send_request(cmd, ($urandom_range(19) == 0) ? 16'($urandom) : pick_id(), $urandom,
                   ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 900)),
                   ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 500)),
                   uptime);
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      task_id[i] = '0;
      task_ctx[i] = '0;
      task_period[i] = '0;
      task_due[i] = '0;
    end
    empty_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_status_commands();
    test_fill_and_fire();
    test_random_schedule(235);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
